### design/fdmm_pkg.sv
// Shared constants, command/status types and controller state encoding for the
// frame-difference motion meter. No dependencies; used by the controller, datapath, top level and testbench.
package fdmm_pkg;

    // Field and register widths.
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned PIX_W   = 3 * CHAN_W;
    localparam int unsigned CFG_W   = 20;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned OUT_W   = 8;

    // Defaults.
    localparam int unsigned        MAX_PIXELS_DEF     = 524288;
    localparam logic [CFG_W-1:0]   FRAME_PIXELS_RESET = 20'd307200;

    // Arithmetic constants of the percentage: floor((200*sum + 765*n) / (1530*n)).
    localparam int unsigned CHANNEL_MAX   = 255;
    localparam int unsigned PERCENT_SCALE = 100;
    localparam int unsigned CHANNELS      = 3;
    localparam int unsigned NUM_SCALE     = 2 * PERCENT_SCALE;
    localparam int unsigned RND_SCALE     = CHANNELS * CHANNEL_MAX;
    localparam int unsigned DEN_SCALE     = 2 * CHANNELS * CHANNEL_MAX;

    // The quotient never exceeds 100, so seven restoring steps suffice.
    localparam int unsigned QUOT_BITS = PCT_W;
    localparam int unsigned IDX_W     = $clog2(QUOT_BITS);

    // Divider sequencer states, one-hot.
    typedef enum logic [4:0] {
        DIV_IDLE = 5'b00001,
        DIV_MUL  = 5'b00010,
        DIV_ADD  = 5'b00100,
        DIV_STEP = 5'b01000,
        DIV_DONE = 5'b10000
    } div_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             pix_load;
        logic             acc_add;
        logic             acc_clear;
        logic             div_launch;
        logic             mul_load;
        logic             add_load;
        logic             div_step;
        logic [IDX_W-1:0] div_idx;
        logic             out_load;
    } fdmm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_end;
    } fdmm_stat_t;

endpackage

### design/fdmm_ctrl.sv
// Controller of the frame-difference motion meter: input handshake, pixel
// pipeline flags, divider sequencer and output valid. Depends on fdmm_pkg.
module fdmm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  fdmm_pkg::fdmm_stat_t stat,
    output fdmm_pkg::fdmm_cmd_t  cmd
);
    import fdmm_pkg::*;

    div_state_t       state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic             st2_valid_reg, st2_valid_next;
    logic             st2_eof_reg, st2_eof_next;
    logic             ref_valid_reg, ref_valid_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             accept;
    logic             launch;

    // A pixel that closes a frame waits until the divider is free.
    assign s_tready = !(stat.frame_end &&
                        (state_reg != DIV_IDLE || (st2_valid_reg && st2_eof_reg)));
    assign accept   = s_tvalid && s_tready;
    assign launch   = st2_valid_reg && st2_eof_reg && ref_valid_reg;
    assign m_tvalid = m_tvalid_reg;

    // Second pixel stage flags and the reference-frame flag.
    always_comb begin
        st2_valid_next = accept;
        st2_eof_next   = accept && stat.frame_end;
        ref_valid_next = ref_valid_reg || (st2_valid_reg && st2_eof_reg);
    end

    // Divider sequencer and output register control.
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        cmd            = '0;
        cmd.pix_load   = accept;
        cmd.acc_add    = st2_valid_reg && ref_valid_reg;
        cmd.acc_clear  = st2_valid_reg && st2_eof_reg;
        cmd.div_launch = launch;
        cmd.div_idx    = step_reg;

        case (state_reg)
            DIV_IDLE: begin
                if (launch) begin
                    state_next = DIV_MUL;
                end
            end
            DIV_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = DIV_ADD;
            end
            DIV_ADD: begin
                cmd.add_load = 1'b1;
                step_next    = IDX_W'(QUOT_BITS - 1);
                state_next   = DIV_STEP;
            end
            DIV_STEP: begin
                cmd.div_step = 1'b1;
                if (step_reg == '0) begin
                    state_next = DIV_DONE;
                end else begin
                    step_next = step_reg - IDX_W'(1);
                end
            end
            DIV_DONE: begin
                if (!m_tvalid_reg) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = DIV_IDLE;
                end
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= DIV_IDLE;
            step_reg      <= '0;
            st2_valid_reg <= 1'b0;
            st2_eof_reg   <= 1'b0;
            ref_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            st2_valid_reg <= st2_valid_next;
            st2_eof_reg   <= st2_eof_next;
            ref_valid_reg <= ref_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

endmodule

### design/fdmm_datapath.sv
// Datapath of the frame-difference motion meter: frame store, pixel position,
// difference accumulator and the shared restoring divider. Depends on fdmm_pkg.
module fdmm_datapath #(
    parameter int unsigned MAX_PIXELS = fdmm_pkg::MAX_PIXELS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [fdmm_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic [fdmm_pkg::PIX_W-1:0]  s_tdata,
    output logic [fdmm_pkg::OUT_W-1:0]  m_tdata,
    input  fdmm_pkg::fdmm_cmd_t         cmd,
    output fdmm_pkg::fdmm_stat_t        stat
);
    import fdmm_pkg::*;

    localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int unsigned CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam longint unsigned SUM_MAX = longint'(RND_SCALE) * longint'(MAX_PIXELS);
    localparam longint unsigned NUM_MAX = longint'(NUM_SCALE) * SUM_MAX
                                        + longint'(RND_SCALE) * longint'(MAX_PIXELS);
    localparam longint unsigned DEN_MAX = longint'(DEN_SCALE) * longint'(MAX_PIXELS);
    localparam int unsigned SUM_W  = $clog2(SUM_MAX + 1);
    localparam int unsigned NUM_W  = $clog2(NUM_MAX + 1);
    localparam int unsigned DEN_W  = $clog2(DEN_MAX + 1);
    localparam int unsigned WK_W   =
        ((NUM_W > DEN_W + QUOT_BITS) ? NUM_W : DEN_W + QUOT_BITS) + 1;

    // Frame store: one write and one registered read at the same address.
    logic [PIX_W-1:0]  frame_mem [MAX_PIXELS];

    logic [CFG_W-1:0]  frame_pixels_reg;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [PIX_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  prev_reg;
    logic [CNT_W-1:0]  count2_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]  total_reg;
    logic [CNT_W-1:0]  cnt_div_reg;
    logic [NUM_W-1:0]  prod_a_reg;
    logic [NUM_W-1:0]  prod_b_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [WK_W-1:0]   rem_reg;
    logic [PCT_W-1:0]  quot_reg;
    logic [PCT_W-1:0]  out_data_reg;

    logic [CNT_W-1:0]  count;
    logic [CW-1:0]     n_eff;
    logic [CHAN_W-1:0] d_blue, d_green, d_red;
    logic [CHAN_W+1:0] pix_diff;
    logic [SUM_W-1:0]  sum_plus;
    logic [WK_W-1:0]   den_shift;

    // Effective frame length: zero counts as one, large values clamp.
    always_comb begin
        if (frame_pixels_reg == '0) begin
            n_eff = CW'(1);
        end else if (CW'(frame_pixels_reg) > CW'(MAX_PIXELS)) begin
            n_eff = CW'(MAX_PIXELS);
        end else begin
            n_eff = CW'(frame_pixels_reg);
        end
    end

    assign count          = CNT_W'(pos_reg) + CNT_W'(1);
    assign stat.frame_end = CW'(count) >= n_eff;

    always_comb begin
        pos_next = pos_reg;
        if (cmd.pix_load) begin
            pos_next = stat.frame_end ? '0 : pos_reg + ADDR_W'(1);
        end
    end

    // Configuration register and pixel position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pixels_reg <= FRAME_PIXELS_RESET;
            pos_reg          <= '0;
        end else begin
            if (cfg_wr_en) begin
                frame_pixels_reg <= cfg_wr_data;
            end
            pos_reg <= pos_next;
        end
    end

    // Stage one: read the reference pixel and store the new one.
    always_ff @(posedge aclk) begin
        if (cmd.pix_load) begin
            frame_mem[pos_reg] <= s_tdata;
            prev_reg           <= frame_mem[pos_reg];
            pix_reg            <= s_tdata;
            count2_reg         <= count;
        end
    end

    // Stage two: absolute channel differences.
    always_comb begin
        d_blue   = (pix_reg[7:0] > prev_reg[7:0]) ? pix_reg[7:0] - prev_reg[7:0]
                                                  : prev_reg[7:0] - pix_reg[7:0];
        d_green  = (pix_reg[15:8] > prev_reg[15:8]) ? pix_reg[15:8] - prev_reg[15:8]
                                                    : prev_reg[15:8] - pix_reg[15:8];
        d_red    = (pix_reg[23:16] > prev_reg[23:16]) ? pix_reg[23:16] - prev_reg[23:16]
                                                      : prev_reg[23:16] - pix_reg[23:16];
        pix_diff = (CHAN_W + 2)'(d_blue) + (CHAN_W + 2)'(d_green) + (CHAN_W + 2)'(d_red);
        sum_plus = sum_reg + SUM_W'(pix_diff);
    end

    always_comb begin
        sum_next = sum_reg;
        if (cmd.acc_clear) begin
            sum_next = '0;
        end else if (cmd.acc_add) begin
            sum_next = sum_plus;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    // Capture the finished frame's sum and pixel count for the divider.
    always_ff @(posedge aclk) begin
        if (cmd.div_launch) begin
            total_reg   <= sum_plus;
            cnt_div_reg <= count2_reg;
        end
    end

    assign den_shift = WK_W'(den_reg) << cmd.div_idx;

    // Divider: scale, form the rounded numerator, then one quotient bit a cycle.
    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            prod_a_reg <= NUM_W'(total_reg) * NUM_W'(NUM_SCALE);
            prod_b_reg <= NUM_W'(cnt_div_reg) * NUM_W'(RND_SCALE);
            den_reg    <= DEN_W'(cnt_div_reg) * DEN_W'(DEN_SCALE);
        end
        if (cmd.add_load) begin
            rem_reg  <= WK_W'(prod_a_reg) + WK_W'(prod_b_reg);
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_reg >= den_shift) begin
                rem_reg               <= rem_reg - den_shift;
                quot_reg[cmd.div_idx] <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            out_data_reg <= quot_reg;
        end
    end

    assign m_tdata = {1'b0, out_data_reg};

endmodule

### design/frame_difference_motion_meter.sv
// Top level of the frame-difference motion meter: controller plus datapath.
// Depends on fdmm_pkg, fdmm_ctrl and fdmm_datapath.
//
// Usage:
//   s_* channel takes one BGR pixel per item in raster order; tdata holds
//   blue, green, red from bit 0 up. m_* channel gives one item per finished
//   frame after the first: motion_percent in tdata[6:0], tdata[7] is zero.
//   cfg_wr_en/cfg_wr_data write frame_pixels (0 acts as 1, values above
//   MAX_PIXELS act as MAX_PIXELS); write it only while the block is idle.
// Throughput: one pixel per cycle, but the pixel that closes a frame is held off
//   while the previous frame's division is still running, so short frames are
//   limited by the divider.
// Result path: after the last pixel of a frame is accepted, the result passes
//   one difference stage, two scaling steps, seven quotient steps of the restoring
//   divider and one output load, and waits while the output is still full.
// Reset: synchronous, active low; clears position, sum, reference flag and
//   the output valid. The frame store needs no clearing: the first frame after
//   reset only fills it and gives no result.
// Stall: a waiting result sits in the output register while pixels keep
//   flowing; a second result waits in the divider until the first is taken.
module frame_difference_motion_meter #(
    parameter int unsigned MAX_PIXELS = fdmm_pkg::MAX_PIXELS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [fdmm_pkg::CFG_W-1:0]  cfg_wr_data,   // frame_pixels
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fdmm_pkg::PIX_W-1:0]  s_tdata,       // blue[7:0], green[15:8], red[23:16]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fdmm_pkg::OUT_W-1:0]  m_tdata        // motion_percent[6:0], zero pad[7]
);
    import fdmm_pkg::*;

    fdmm_cmd_t  cmd;
    fdmm_stat_t stat;

    fdmm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fdmm_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

### design/fdmm_checker.sv
// Port-level checks for the frame-difference motion meter and the bind that
// attaches them to the top level. Depends on frame_difference_motion_meter.
module fdmm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (
        @(posedge aclk) !aresetn |=> !m_tvalid
    ) else $error("m_tvalid high in the cycle after reset");

    // A percentage never exceeds one hundred.
    a_percent_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= 8'd100)
    ) else $error("motion_percent above 100");

    // A stalled result stays put.
    a_out_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
    ) else $error("stalled result dropped or changed");

endmodule

bind frame_difference_motion_meter fdmm_checker u_fdmm_checker (.*);

### tb/sv/fdmm_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the frame-difference motion meter: watches the pixel, result
// and register ports, predicts every motion percentage and compares it.
// Depends on fdmm_pkg for the port and field widths only.
module fdmm_scoreboard (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [fdmm_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [fdmm_pkg::PIX_W-1:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [fdmm_pkg::OUT_W-1:0] m_tdata,   // motion_percent[6:0], pad[7]
    output int unsigned                fail_count,
    output int unsigned                pending
);
    import fdmm_pkg::*;

    localparam int unsigned STORE_DEPTH     = 524288;
    localparam int unsigned PIXELS_AT_RESET = 307200;
    localparam int unsigned PERCENT         = 100;
    localparam int unsigned FULL_SCALE      = 255;
    localparam int unsigned NUM_CHANNELS    = 3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } bgr_t;

    // Model state: the stored reference frame and the running frame totals.
    bgr_t              stored_frame [STORE_DEPTH];
    logic [CFG_W-1:0]  frame_pixels;
    int unsigned       position;
    longint unsigned   diff_sum;
    bit                have_reference;
    logic [PCT_W-1:0]  expected_pct [$];
    int unsigned       result_index;
    int unsigned       failures;

    initial begin
        fail_count     = 0;
        pending        = 0;
        failures       = 0;
        result_index   = 0;
        position       = 0;
        diff_sum       = 0;
        have_reference = 1'b0;
        frame_pixels   = CFG_W'(PIXELS_AT_RESET);
    end

    // A register value of zero acts as one pixel; large values clamp to the store.
    function automatic int unsigned pixels_in_frame(input logic [CFG_W-1:0] cfg);
        if (cfg == '0) begin
            return 1;
        end
        if (cfg > STORE_DEPTH) begin
            return STORE_DEPTH;
        end
        return cfg;
    endfunction

    function automatic int unsigned channel_gap(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic report_mismatch(input string what);
        failures++;
        $display("[%0t] fdmm_scoreboard: %s", $time, what);
    endtask

    // Accumulate one pixel against the stored frame and close the frame when due.
    task automatic take_pixel(input bgr_t px);
        int unsigned     limit;
        longint unsigned count;
        longint unsigned num;
        longint unsigned den;
        bgr_t            prior;
        limit = pixels_in_frame(frame_pixels);
        if (have_reference) begin
            prior = stored_frame[position];
            diff_sum += channel_gap(px.blue, prior.blue)
                      + channel_gap(px.green, prior.green)
                      + channel_gap(px.red, prior.red);
        end
        stored_frame[position] = px;
        count = position + 1;
        if (count < limit) begin
            position = count;
        end else begin
            position = 0;
            if (!have_reference) begin
                // The first frame only fills the store.
                have_reference = 1'b1;
            end else begin
                // Mean difference in percent, rounded half up.
                num = 2 * PERCENT * diff_sum + NUM_CHANNELS * FULL_SCALE * count;
                den = 2 * NUM_CHANNELS * FULL_SCALE * count;
                expected_pct.push_back(PCT_W'(num / den));
            end
            diff_sum = 0;
        end
    endtask

    task automatic check_result(input logic [OUT_W-1:0] word);
        logic [PCT_W-1:0] want;
        if (expected_pct.size() == 0) begin
            report_mismatch($sformatf("result %0d: motion %0d with no frame pending",
                                      result_index, word[PCT_W-1:0]));
        end else begin
            want = expected_pct.pop_front();
            if (word[PCT_W-1:0] !== want) begin
                report_mismatch($sformatf("result %0d: motion_percent %0d, predicted %0d",
                                          result_index, word[PCT_W-1:0], want));
            end
            if (word[OUT_W-1:PCT_W] !== '0) begin
                report_mismatch($sformatf("result %0d: pad bits %b are not zero",
                                          result_index, word[OUT_W-1:PCT_W]));
            end
        end
        result_index++;
    endtask

    // Sample every handshake at the clock edge. A pixel taken at the same edge
    // as a register write still sees the old frame size.
    always @(posedge aclk) begin
        if (!aresetn) begin
            position       = 0;
            diff_sum       = 0;
            have_reference = 1'b0;
            frame_pixels   = CFG_W'(PIXELS_AT_RESET);
            expected_pct.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                take_pixel(bgr_t'(s_tdata));
            end
            if (cfg_wr_en) begin
                frame_pixels = cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
            end
        end
        pending    <= expected_pct.size();
        fail_count <= failures;
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the frame-difference motion meter testbench: clock, reset, pixel and
// register stimulus, result back-pressure and the verdict. Needs fdmm_pkg,
// fdmm_scoreboard and the frame_difference_motion_meter RTL.
module testbench;
    import fdmm_pkg::*;

    localparam int unsigned FILL_PIXELS      = 384;
    localparam int unsigned FULL_SCALE_FRAME = 64;
    localparam int unsigned LONG_FRAME       = 300;
    localparam int unsigned SETTLE_CYCLES    = 16;
    localparam int unsigned DRAIN_LIMIT      = 5000;
    localparam int unsigned STALL_CYCLES     = 400;
    localparam int unsigned GROUP_ITEMS      = 250;
    localparam int unsigned PROBE_FRAME      = 40;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [PIX_W-1:0] s_tdata     = '0;
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    int unsigned      fail_count;
    int unsigned      pending;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned stall_requests = 0;

    frame_difference_motion_meter DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    fdmm_scoreboard motion_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #50_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Result side: random back-pressure, plus long hold-offs on request.
    initial begin
        int unsigned hold_left;
        int unsigned stalls_served;
        hold_left     = 0;
        stalls_served = 0;
        forever begin
            @(posedge aclk);
            if (stall_requests != stalls_served) begin
                stalls_served++;
                hold_left = STALL_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one pixel item, with random idle cycles ahead of it.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= PIX_W'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_frame_pixels(input logic [CFG_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending, wait for every predicted result, then let the pipeline empty.
    task automatic wait_drained();
        int unsigned waited;
        waited   = 0;
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            waited++;
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Pattern of full-scale channels for the fill and full-scale frames.
    function automatic logic [PIX_W-1:0] board_pixel(input int unsigned p, input int unsigned mask);
        int unsigned v;
        v = p ^ mask ^ (p >> 5);
        return {{CHAN_W{v[2]}}, {CHAN_W{v[1]}}, {CHAN_W{v[0]}}};
    endfunction

    // One setting of the frame size followed by a run of pixels.
    task automatic run_phase(output int unsigned items);
        int unsigned      kind;
        int unsigned      n;
        int unsigned      eff;
        int unsigned      budget;
        int unsigned      scene;
        int unsigned      scene_mask;
        int unsigned      hit;
        int unsigned      level;
        int unsigned      bits;
        logic [PIX_W-1:0] px;
        kind  = $urandom_range(99);
        items = 0;
        if (kind < 10) begin
            // Rounding probe: with 40 pixels a sum of 153 lies exactly on a half.
            write_frame_pixels(CFG_W'(1));
            send_pixel(PIX_W'($urandom));
            wait_drained();
            write_frame_pixels(CFG_W'(PROBE_FRAME));
            for (int f = 0; f < 4; f++) begin
                hit   = $urandom_range(PROBE_FRAME - 1);
                level = $urandom_range(148, 158);
                for (int q = 0; q < PROBE_FRAME; q++) begin
                    if (f % 2 == 1 && q == hit) begin
                        send_pixel({CHAN_W'(level - 2 * (level / 3)), CHAN_W'(level / 3),
                                    CHAN_W'(level / 3)});
                    end else begin
                        send_pixel('0);
                    end
                end
            end
            items = 1 + 4 * PROBE_FRAME;
        end else begin
            if (kind < 15) begin
                n = 0;
            end else if (kind < 55) begin
                n = $urandom_range(1, 8);
            end else if (kind < 85) begin
                n = $urandom_range(9, 64);
            end else if (kind < 95) begin
                n = $urandom_range(65, LONG_FRAME);
            end else begin
                n = $urandom_range((1 << CFG_W) - 1);
            end
            write_frame_pixels(CFG_W'(n));
            eff = (n == 0) ? 1 : n;
            if (n == 0) begin
                budget = $urandom_range(4, 20);
            end else if (n <= 64) begin
                budget = $urandom_range(1, 6) * n + $urandom_range(n - 1);
            end else if (n <= LONG_FRAME) begin
                budget = n + $urandom_range(n);
            end else begin
                budget = $urandom_range(20, 80);
            end
            scene      = $urandom_range(2);
            scene_mask = $urandom;
            for (int unsigned p = 0; p < budget; p++) begin
                bits = $urandom;
                case (scene)
                    0: begin
                        px = PIX_W'(bits);
                    end
                    1: begin
                        // Still scene with occasional moving pixels.
                        if (bits[3:0] == 4'd0) begin
                            px = PIX_W'($urandom);
                        end else begin
                            px = PIX_W'((scene_mask ^ ((p % eff) * 32'h9E3779B1)) >> 5);
                        end
                    end
                    default: begin
                        px = {{CHAN_W{bits[2]}}, {CHAN_W{bits[1]}}, {CHAN_W{bits[0]}}};
                    end
                endcase
                send_pixel(px);
            end
            items = budget;
            if (n > LONG_FRAME) begin
                // Close the long frame so every later pixel lands in the filled store.
                wait_drained();
                write_frame_pixels(CFG_W'(1));
                send_pixel(PIX_W'($urandom));
                items = budget + 1;
            end
        end
        wait_drained();
    endtask

    // Stimulus and verdict.
    initial begin
        int unsigned board_mask;
        int unsigned sent;
        int unsigned phase_items;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the low end of the store first; no later pixel position reaches past it.
        write_frame_pixels(CFG_W'(FILL_PIXELS));
        board_mask = $urandom;
        for (int unsigned p = 0; p < FILL_PIXELS; p++) begin
            send_pixel(board_pixel(p, board_mask));
        end
        wait_drained();
        // Full-scale difference on every channel gives one hundred percent.
        write_frame_pixels(CFG_W'(FULL_SCALE_FRAME));
        for (int unsigned p = 0; p < FULL_SCALE_FRAME; p++) begin
            send_pixel(~board_pixel(p, board_mask));
        end
        wait_drained();

        // A zero pixel count acts as one pixel per frame.
        write_frame_pixels('0);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h0000FF);
        wait_drained();
        write_frame_pixels(CFG_W'(1));
        send_pixel(24'hFF00FF);
        send_pixel(24'h00FF00);
        wait_drained();
        write_frame_pixels(CFG_W'(3));
        send_pixel(24'h0000FF);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF0000);
        send_pixel(24'hFF0000);
        send_pixel(24'h0000FF);
        send_pixel(24'h00FF00);
        wait_drained();

        // Shrink the frame below the current position: the next pixel closes it.
        write_frame_pixels(CFG_W'(10));
        repeat (4) send_pixel(PIX_W'($urandom));
        wait_drained();
        write_frame_pixels(CFG_W'(2));
        send_pixel(24'h808080);
        wait_drained();

        // Grow the frame while it is open.
        send_pixel(PIX_W'($urandom));
        wait_drained();
        write_frame_pixels(CFG_W'(6));
        repeat (5) send_pixel(PIX_W'($urandom));
        wait_drained();

        // Random phases under three back-pressure mixes.
        for (int grp = 0; grp < 3; grp++) begin
            send_idle_pct = (grp == 0) ? 14 : (grp == 1) ? 58 : 0;
            recv_idle_pct <= (grp == 0) ? 58 : (grp == 1) ? 14 : 0;
            if (grp == 2) begin
                // Hold the result side off while short frames keep arriving.
                write_frame_pixels(CFG_W'(2));
                stall_requests <= stall_requests + 1;
                repeat (80) send_pixel(PIX_W'($urandom));
                wait_drained();
            end
            sent = 0;
            while (sent < GROUP_ITEMS) begin
                run_phase(phase_items);
                sent += phase_items;
            end
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

### files.f
design/fdmm_pkg.sv
design/fdmm_ctrl.sv
design/fdmm_datapath.sv
design/frame_difference_motion_meter.sv
design/fdmm_checker.sv
tb/sv/fdmm_checker.sv
tb/sv/testbench.sv
